@@ rtl/fspe_pkg.sv @@
// Package for the FELICS-style pixel encoder.
// Holds the field widths, code constants, register indexes and the item
// type shared by the front end, the coder and the top level. No dependencies.
package fspe_pkg;

  // Field widths of the streams and the configuration port.
  localparam int SAMPLE_W   = 8;
  localparam int MAP_W      = 9;
  localparam int CODE_W     = 37;
  localparam int LEN_W      = 6;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int PPR_W      = 11;
  localparam int NC_W       = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Code construction: quotient step of sixteen, five remainder bits.
  localparam int QUOT_SHIFT = 4;
  localparam int QUOT_W     = MAP_W - QUOT_SHIFT;
  localparam int REM_BITS   = 5;
  localparam int ONES_W     = CODE_W - REM_BITS;
  localparam int WIN_BIAS   = 80;

  // Parameter defaults.
  localparam int DEF_MAX_ROW_PIXELS = 1024;
  localparam int DEF_MAX_COMPONENTS = 4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENTS     = 1'b1;
  localparam logic [PPR_W-1:0]     PPR_RESET = 11'd1024;
  localparam logic [NC_W-1:0]      NC_RESET  = 3'd1;

  // One item on its way from the front end to the coder.
  typedef struct packed {
    logic             plain;  // first pixel of a row or first row: unary code
    logic [MAP_W-1:0] value;  // raw byte or zigzag-mapped left difference
    logic [MAP_W-1:0] left;   // last coded value of the same component
  } item_t;

endpackage

@@ rtl/felics_style_pixel_encoder.sv @@
// FELICS-style pixel encoder: one codeword per 8-bit sample.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle when not held off by a configuration write or a stalled output;
// the line store takes one read and one write a cycle. After a configuration write, input
// is held off while the component counter is realigned.
// Reset (synchronous): start of a first row, 1024 pixels, one component; no store cleared.
module felics_style_pixel_encoder #(
  parameter int MAX_ROW_PIXELS = fspe_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_COMPONENTS = fspe_pkg::DEF_MAX_COMPONENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fspe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [fspe_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] sample
  input  logic                               s_tuser,   // [0] frame_start
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [fspe_pkg::OUT_TDATA_W-1:0]   m_tdata    // [36:0] code, [42:37] code_length
);
  import fspe_pkg::*;

  logic             item_valid, item_ready;
  item_t            item;
  logic [MAP_W-1:0] up;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  code_length;

  fspe_front #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample      (s_tdata[SAMPLE_W-1:0]),
    .frame_start (s_tuser),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .up          (up)
  );

  fspe_coder u_coder (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .up          (up),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .code        (code),
    .code_length (code_length)
  );

  // Pack the result item, padded with zeros to whole bytes.
  assign m_tdata = {{(OUT_TDATA_W - CODE_W - LEN_W){1'b0}}, code_length, code};

endmodule

@@ rtl/fspe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-first on a shared address. Depends on nothing.
module fspe_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fspe_front.sv @@
// Front end of the encoder: configuration registers, row position, component
// counter, per-component history, line store and the input register.
// Depends on fspe_pkg and fspe_ram.
module fspe_front #(
  parameter int MAX_ROW_PIXELS = fspe_pkg::DEF_MAX_ROW_PIXELS,
  parameter int MAX_COMPONENTS = fspe_pkg::DEF_MAX_COMPONENTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fspe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fspe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fspe_pkg::SAMPLE_W-1:0]    sample,
  input  logic                             frame_start,
  output logic                             item_valid,
  input  logic                             item_ready,
  output fspe_pkg::item_t                  item,
  output logic [fspe_pkg::MAP_W-1:0]       up
);
  import fspe_pkg::*;

  localparam int LINE_DEPTH = MAX_ROW_PIXELS * MAX_COMPONENTS;
  localparam int PW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int RLW  = $clog2(LINE_DEPTH + 1);
  localparam int PPW  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int CWP  = (PPW > PPR_W) ? PPW : PPR_W;
  localparam int NCW  = $clog2(MAX_COMPONENTS + 1);
  localparam int CWN  = (NCW > NC_W) ? NCW : NC_W;
  localparam int CIW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int RW   = PW + CWN;
  localparam int KW   = $clog2(PW + 1);
  localparam logic [CWP-1:0] PPR_MAX = CWP'(MAX_ROW_PIXELS);
  localparam logic [CWN-1:0] NC_MAX  = CWN'(MAX_COMPONENTS);

  // Configuration and position state.
  logic [PPR_W-1:0] ppr_reg;
  logic [NC_W-1:0]  nc_reg;
  logic [PW-1:0]    column;
  logic             first_row;
  logic [CIW-1:0]   comp;
  logic             busy;
  logic [KW-1:0]    kcnt;
  logic [PW-1:0]    rem;

  // Per-component history.
  logic [SAMPLE_W-1:0] recent_raw    [MAX_COMPONENTS];
  logic [MAP_W-1:0]    recent_mapped [MAX_COMPONENTS];

  logic [CWP-1:0] ppr_x, ppr_eff;
  logic [CWN-1:0] nc_x, nc_eff;
  logic [RLW-1:0] row_len;
  logic           accept;

  // Clamp the registers into range and form the row length in samples.
  always_comb begin
    ppr_x = CWP'(ppr_reg);
    nc_x  = CWN'(nc_reg);
    priority if (ppr_x == '0) begin
      ppr_eff = CWP'(1);
    end else if (ppr_x > PPR_MAX) begin
      ppr_eff = PPR_MAX;
    end else begin
      ppr_eff = ppr_x;
    end
    priority if (nc_x == '0) begin
      nc_eff = CWN'(1);
    end else if (nc_x > NC_MAX) begin
      nc_eff = NC_MAX;
    end else begin
      nc_eff = nc_x;
    end
    row_len = RLW'(ppr_eff) * RLW'(nc_eff);
  end

  assign in_ready = !busy && (!item_valid || item_ready);
  assign accept   = in_valid && in_ready;

  logic [PW-1:0]      col0, pos;
  logic               first0, first1;
  logic [CIW-1:0]     c0, c1;
  logic               raw;
  logic [SAMPLE_W:0]  diff;
  logic [MAP_W-1:0]   mapped, cur;
  logic [RLW-1:0]     pos_inc;
  logic               row_end;

  // Position of this item, mapped left difference and the coded value.
  always_comb begin
    col0   = frame_start ? '0 : column;
    first0 = frame_start ? 1'b1 : first_row;
    c0     = frame_start ? '0 : comp;
    if (RLW'(col0) >= row_len) begin
      pos    = '0;
      first1 = 1'b0;
      c1     = '0;
    end else begin
      pos    = col0;
      first1 = first0;
      c1     = c0;
    end
    raw  = RLW'(pos) < RLW'(nc_eff);
    diff = {1'b0, recent_raw[c1]} - {1'b0, sample};
    if (diff[SAMPLE_W]) begin
      mapped = {~diff[SAMPLE_W-1:0], 1'b1};
    end else begin
      mapped = {diff[SAMPLE_W-1:0], 1'b0};
    end
    cur     = raw ? {1'b0, sample} : mapped;
    pos_inc = RLW'(pos) + RLW'(1);
    row_end = pos_inc >= row_len;
  end

  // Step of the modulo unit that realigns the component counter after a
  // configuration write: one quotient bit a cycle, most significant first.
  logic [RW-1:0] sub_val;
  logic [PW-1:0] rem_next;
  always_comb begin
    sub_val = RW'(nc_eff) << kcnt;
    if (RW'(rem) >= sub_val) begin
      rem_next = rem - PW'(sub_val);
    end else begin
      rem_next = rem;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ppr_reg    <= PPR_RESET;
      nc_reg     <= NC_RESET;
      column     <= '0;
      first_row  <= 1'b1;
      comp       <= '0;
      busy       <= 1'b0;
      kcnt       <= '0;
      item_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PIXELS_PER_ROW: ppr_reg <= cfg_wdata[PPR_W-1:0];
          REG_COMPONENTS:     nc_reg  <= cfg_wdata[NC_W-1:0];
        endcase
        busy <= 1'b1;
        kcnt <= KW'(PW - 1);
      end else if (busy) begin
        if (kcnt == '0) begin
          busy <= 1'b0;
          comp <= CIW'(rem_next);
        end else begin
          kcnt <= kcnt - KW'(1);
        end
      end
      if (accept) begin
        if (row_end) begin
          column    <= '0;
          first_row <= 1'b0;
          comp      <= '0;
        end else begin
          column    <= pos_inc[PW-1:0];
          first_row <= first1;
          comp      <= (c1 == CIW'(nc_eff - CWN'(1))) ? '0 : c1 + CIW'(1);
        end
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Payload: input register, history and the modulo remainder.
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      rem <= column;
    end else if (busy) begin
      rem <= rem_next;
    end
    if (accept) begin
      item.plain         <= raw || first1;
      item.value         <= cur;
      item.left          <= recent_mapped[c1];
      recent_raw[c1]     <= sample;
      recent_mapped[c1]  <= cur;
    end
  end

  // Line store: coded value at each position of the row above.
  fspe_ram #(
    .WIDTH (MAP_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (cur),
    .re    (accept),
    .raddr (pos),
    .rdata (up)
  );

endmodule

@@ rtl/fspe_coder.sv @@
// Codeword builder and result register of the encoder.
// Forms the unary, escape or window code of one item. Depends on fspe_pkg.
module fspe_coder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fspe_pkg::item_t               item,
  input  logic [fspe_pkg::MAP_W-1:0]    up,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fspe_pkg::CODE_W-1:0]   code,
  output logic [fspe_pkg::LEN_W-1:0]    code_length
);
  import fspe_pkg::*;

  logic [LEN_W-1:0]    k;
  logic [ONES_W-1:0]   ones;
  logic [CODE_W-1:0]   unary_code;
  logic [LEN_W-1:0]    unary_len;
  logic [MAP_W-1:0]    hi, lo, span;
  logic [3:0]          n;
  logic [MAP_W:0]      mask, sum;
  logic [MAP_W+2:0]    start, off;
  logic                win_ok;
  logic [CODE_W-1:0]   code_next;
  logic [LEN_W-1:0]    len_next;

  assign item_ready = !out_valid || out_ready;

  // Unary part: a run of ones, then the remainder in five bits.
  always_comb begin
    k = LEN_W'(item.value[MAP_W-1:QUOT_SHIFT]) + (item.plain ? LEN_W'(0) : LEN_W'(1));
    for (int i = 0; i < ONES_W; i++) begin
      ones[i] = LEN_W'(i) < k;
    end
    unary_code = {ones, {(REM_BITS - QUOT_SHIFT){1'b0}}, item.value[QUOT_SHIFT-1:0]};
    unary_len  = k + LEN_W'(REM_BITS);
  end

  // Window code from the left and up context. Equal context falls out as a
  // window of width one, giving the single zero bit.
  always_comb begin
    if (item.left >= up) begin
      hi = item.left;
      lo = up;
    end else begin
      hi = up;
      lo = item.left;
    end
    span = hi - lo;
    n = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (span[i]) begin
        n = 4'(i + 1);
      end
    end
    mask   = (MAP_W+1)'((11'd1 << n) - 11'd1);
    sum    = {1'b0, hi} + {1'b0, lo};
    start  = (MAP_W+3)'(sum >> 1) - (MAP_W+3)'(mask >> 1);
    off    = (MAP_W+3)'(item.value) - start;
    win_ok = !off[MAP_W+2] && (off <= (MAP_W+3)'(mask))
             && ((MAP_W+1)'({n, 4'b0}) < ((MAP_W+1)'(item.value) + (MAP_W+1)'(WIN_BIAS)));
  end

  // Choice between the plain unary code, the window code and the escape.
  always_comb begin
    if (!item.plain && win_ok) begin
      code_next = CODE_W'(off[MAP_W-1:0]);
      len_next  = LEN_W'(n) + LEN_W'(1);
    end else begin
      code_next = unary_code;
      len_next  = unary_len;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      code        <= code_next;
      code_length <= len_next;
    end
  end

endmodule

@@ rtl/fspe_checker.sv @@
// Port-level checks for the FELICS-style pixel encoder, bound to the top level.
// Depends on fspe_pkg and felics_style_pixel_encoder.
module fspe_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [fspe_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import fspe_pkg::*;

  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;

  assign code = m_tdata[CODE_W-1:0];
  assign len  = m_tdata[CODE_W+LEN_W-1:CODE_W];

  // A result always carries between one and thirty-seven bits.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (len != '0) && (len <= LEN_W'(CODE_W)))
    else $error("code length out of range");

  // No code bit is set above the stated length.
  a_code_fits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((code >> len) == '0))
    else $error("code bits above code length");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind felics_style_pixel_encoder fspe_checker u_fspe_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
